// ===== src/bclm_pkg.sv =====
// Shared types and constants of the busy-counter load meter.
package bclm_pkg;

    localparam int CNT_W   = 32;
    localparam int TPU_W   = 10;
    localparam int TIME_W  = 64;
    localparam int DT_W    = 40;                 // dt range that can still give a nonzero load
    localparam int NUM_W   = 39;                 // 100 * delta
    localparam int DIV_W   = DT_W + TPU_W;       // dt * ticks_per_us
    localparam int Q_W     = 7;                  // quotient bits kept
    localparam int DSH_W   = DIV_W + Q_W;        // divisor aligned to the top quotient bit
    localparam int STEP_W  = 3;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 8;

    localparam logic [Q_W-1:0] LOAD_FULL = 7'd100;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SAVE   = 1'b1;

    localparam logic REG_COUNTER_MAX = 1'b0;
    localparam logic REG_TICKS_PER_US = 1'b1;

    typedef struct packed {
        logic accept_sample;   // latch reading and timestamp
        logic accept_save;     // record saved pre-power-off count
        logic prep;            // delta, dt, state update
        logic mul;             // numerator and divisor products
        logic sat_check;       // first divide step: quotient >= 128
        logic div_step;        // one quotient bit
        logic load_out;        // capture result into output register
    } t_cmd;

endpackage

// ===== src/busy_counter_load_meter.sv =====
// Top level of the busy-counter load meter.
//
// Input stream (s_axis): one request per item. tuser carries the opcode:
// sample or save. A save request records the counter value saved before
// power-off and answers nothing; the block stays ready. A sample request gives
// one result on the output stream (m_axis): load_percent = min(100,
// 100*delta / (dt*ticks_per_us)) and, in tuser, a zero-interval flag.
// A sample is worked through latch, prep, multiply, 8 divide steps of a
// restoring divider and output load; no new request is taken until its
// result is loaded into the output register. The divider does one
// compare-and-subtract per quotient bit.
// The output register parts the two sides: a finished result waits there
// while the next request is already being worked on; if the receiver still
// holds the previous result, the controller waits before loading it.
// Configuration: i_cfg_we/i_cfg_addr/i_cfg_wdata, index 0 counter_max,
// index 1 ticks_per_us; write only while idle.
// Reset (synchronous, active low) empties the output, clears last time,
// last count and saved count, and restores the register defaults.
module busy_counter_load_meter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] counter_value, [32] powered, [96:33] timestamp_us, [103:97] zero
    input  logic [103:0] i_s_axis_tdata,
    // [0] opcode
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [6:0] load_percent, [7] zero
    output logic [7:0]   o_m_axis_tdata,
    // [0] zero_interval
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    bclm_pkg::t_cmd             cmd;
    logic [bclm_pkg::Q_W-1:0]   load;
    logic                       zero;

    bclm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_op    (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd)
    );

    bclm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_data    (i_s_axis_tdata),
        .o_load      (load),
        .o_zero      (zero)
    );

    assign o_m_axis_tdata = {1'b0, load};
    assign o_m_axis_tuser = zero;

endmodule

// ===== src/bclm_datapath.sv =====
// Datapath: state registers, delta/dt forming, products and bit-serial divide.
module bclm_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bclm_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [bclm_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic [bclm_pkg::S_DATA_W-1:0] i_s_data,
    output logic [bclm_pkg::Q_W-1:0]      o_load,
    output logic                          o_zero
);

    logic [bclm_pkg::CNT_W-1:0]  in_value;
    logic                        in_powered;
    logic [bclm_pkg::TIME_W-1:0] in_ts;

    logic [bclm_pkg::CNT_W-1:0]  r_cnt_max;
    logic [bclm_pkg::TPU_W-1:0]  r_tpu;
    logic [bclm_pkg::TIME_W-1:0] r_last_time;
    logic [bclm_pkg::CNT_W-1:0]  r_last_count;
    logic [bclm_pkg::CNT_W-1:0]  r_saved;

    logic [bclm_pkg::CNT_W-1:0]  r_cur;
    logic [bclm_pkg::TIME_W-1:0] r_ts;
    logic [bclm_pkg::CNT_W-1:0]  r_delta;
    logic [bclm_pkg::DT_W-1:0]   r_dt;
    logic                        r_zero;
    logic                        r_big;
    logic [bclm_pkg::NUM_W-1:0]  r_rem;
    logic [bclm_pkg::DSH_W-1:0]  r_dsh;
    logic [bclm_pkg::Q_W-1:0]    r_q;
    logic                        r_sat;
    logic [bclm_pkg::Q_W-1:0]    r_load;
    logic                        r_out_zero;

    logic [bclm_pkg::CNT_W-1:0]  delta;
    logic                        clear_saved;
    logic [bclm_pkg::TIME_W-1:0] dt;
    logic                        ge;
    logic [bclm_pkg::Q_W-1:0]    result;

    assign in_value   = i_s_data[31:0];
    assign in_powered = i_s_data[32];
    assign in_ts      = i_s_data[96:33];

    // Counter delta, modulo 2^32, with wrap and saved-count handling.
    always_comb begin
        clear_saved = 1'b0;
        if (r_saved != '0) begin
            if (r_cur == r_saved) begin
                delta = r_cur - r_last_count;
            end else if (r_saved >= r_last_count) begin
                delta = r_cur + (r_saved - r_last_count);
                clear_saved = 1'b1;
            end else begin
                delta = r_cur + r_saved + (r_cnt_max - r_last_count);
                clear_saved = 1'b1;
            end
        end else if (r_cur >= r_last_count) begin
            delta = r_cur - r_last_count;
        end else begin
            delta = r_cur + (r_cnt_max - r_last_count);
        end
    end

    assign dt = r_ts - r_last_time;
    assign ge = {{(bclm_pkg::DSH_W-bclm_pkg::NUM_W){1'b0}}, r_rem} >= r_dsh;

    always_comb begin
        if (r_zero) begin
            result = bclm_pkg::LOAD_FULL;
        end else if (r_big) begin
            result = '0;
        end else if (r_sat || (r_q > bclm_pkg::LOAD_FULL)) begin
            result = bclm_pkg::LOAD_FULL;
        end else begin
            result = r_q;
        end
    end

    // Configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_max    <= '1;
            r_tpu        <= 10'd26;
            r_last_time  <= '0;
            r_last_count <= '0;
            r_saved      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == bclm_pkg::REG_COUNTER_MAX)) begin
                r_cnt_max <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_addr == bclm_pkg::REG_TICKS_PER_US)) begin
                r_tpu <= i_cfg_wdata[bclm_pkg::TPU_W-1:0];
            end
            if (i_cmd.accept_save) begin
                r_saved <= in_value;
            end
            if (i_cmd.prep) begin
                r_last_time  <= r_ts;
                r_last_count <= r_cur;
                if (clear_saved) begin
                    r_saved <= '0;
                end
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_sample) begin
            r_cur <= in_powered ? in_value : '0;
            r_ts  <= in_ts;
        end
        if (i_cmd.prep) begin
            r_delta <= delta;
            r_dt    <= dt[bclm_pkg::DT_W-1:0];
            r_zero  <= (dt == '0) || (r_tpu == '0);
            r_big   <= |dt[bclm_pkg::TIME_W-1:bclm_pkg::DT_W];
        end
        if (i_cmd.mul) begin
            r_rem <= bclm_pkg::NUM_W'(r_delta) * bclm_pkg::NUM_W'(bclm_pkg::LOAD_FULL);
            r_dsh <= {bclm_pkg::DIV_W'(r_dt) * bclm_pkg::DIV_W'(r_tpu),
                      {bclm_pkg::Q_W{1'b0}}};
            r_q   <= '0;
            r_sat <= 1'b0;
        end
        if (i_cmd.sat_check) begin
            r_sat <= ge;
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh[bclm_pkg::NUM_W-1:0];
            end
            r_q   <= {r_q[bclm_pkg::Q_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.load_out) begin
            r_load     <= result;
            r_out_zero <= r_zero;
        end
    end

    assign o_load = r_load;
    assign o_zero = r_out_zero;

endmodule

// ===== src/bclm_ctrl.sv =====
// Controller: sequences one sample through prep, multiply, divide, output.
module bclm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  logic           i_s_op,
    output logic           o_s_ready,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output bclm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [bclm_pkg::STEP_W-1:0] r_step;
    logic                        r_m_valid;
    logic                        accept;
    logic                        out_free;

    assign accept   = i_s_valid && (r_state == ST_IDLE);
    assign out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_s_op == bclm_pkg::OP_SAVE) begin
                        o_cmd.accept_save = 1'b1;
                    end else begin
                        o_cmd.accept_sample = 1'b1;
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == '1) begin
                    o_cmd.sat_check = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '1;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_step <= r_step - 1'b1;
            end else begin
                r_step <= '1;
            end
            if (o_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

// ===== src/bclm_checker.sv =====
// Port-level checks of the load meter, bound to the top level.
module bclm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [7:0]   o_m_axis_tdata,
    input logic         o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[6:0] <= bclm_pkg::LOAD_FULL)
        else $error("load above full scale");

    a_zero_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[6:0] == bclm_pkg::LOAD_FULL)
        else $error("zero interval without full load");

    a_save_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == bclm_pkg::OP_SAVE)
        && !o_m_axis_tvalid |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("save request produced a result or stalled");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == bclm_pkg::OP_SAMPLE)
        |=> !o_s_axis_tready)
        else $error("sample request not taken into work");

endmodule

bind busy_counter_load_meter bclm_checker u_bclm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ===== tb/tb_busy_counter_load_meter.sv =====
// Testbench for the busy-counter load meter: random and directed streams, scoreboard check.

// One request on the input stream, decoded.
typedef struct {
    logic        op;
    logic [31:0] value;
    logic        powered;
    logic [63:0] stamp;
} t_meter_req;

// One load result as the block should give it.
typedef struct {
    logic [6:0] load;
    logic       zero_flag;
} t_load_result;

// Tracks counter and time history the way the block does and holds the
// loads still owed by the block.
class load_checker;
    logic [31:0]  counter_max;
    logic [9:0]   ticks_per_us;
    logic [63:0]  last_stamp;
    logic [31:0]  last_count;
    logic [31:0]  saved_count;
    t_load_result expected_loads[$];
    int           error_count;

    function new();
        counter_max  = 32'hFFFF_FFFF;
        ticks_per_us = 10'd26;
        last_stamp   = '0;
        last_count   = '0;
        saved_count  = '0;
        error_count  = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
        if (idx == bclm_pkg::REG_COUNTER_MAX) begin
            counter_max = value;
        end else begin
            ticks_per_us = value[9:0];
        end
    endfunction

    // Busy ticks since the last sample, 32-bit wrap, saved count honored.
    function logic [31:0] busy_delta(logic [31:0] reading);
        logic [31:0] d;
        if (saved_count != '0) begin
            if (reading == saved_count) begin
                d = reading - last_count;
            end else begin
                if (saved_count >= last_count) begin
                    d = reading + (saved_count - last_count);
                end else begin
                    d = reading + saved_count + (counter_max - last_count);
                end
                saved_count = '0;
            end
        end else if (reading >= last_count) begin
            d = reading - last_count;
        end else begin
            d = reading + (counter_max - last_count);
        end
        return d;
    endfunction

    function void note_request(t_meter_req r);
        logic [31:0]  reading;
        logic [31:0]  delta;
        logic [63:0]  dt;
        logic [63:0]  numer;
        logic [63:0]  quot;
        t_load_result res;
        if (r.op == bclm_pkg::OP_SAVE) begin
            saved_count = r.value;
            return;
        end
        reading    = r.powered ? r.value : 32'd0;
        dt         = r.stamp - last_stamp;
        delta      = busy_delta(reading);
        last_stamp = r.stamp;
        last_count = reading;
        numer      = {32'd0, delta} * 64'(bclm_pkg::LOAD_FULL);
        res.zero_flag = 1'b0;
        if (dt == '0 || ticks_per_us == '0) begin
            res.load      = bclm_pkg::LOAD_FULL;
            res.zero_flag = 1'b1;
        end else if (dt >= (64'd1 << 40)) begin
            res.load = '0;
        end else begin
            quot     = numer / (dt * 64'(ticks_per_us));
            res.load = (quot > 64'(bclm_pkg::LOAD_FULL)) ? bclm_pkg::LOAD_FULL : quot[6:0];
        end
        expected_loads.push_back(res);
    endfunction

    task report(string msg);
        if (error_count < 100) $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task check_result(logic [7:0] data, logic user);
        t_load_result want;
        if (expected_loads.size() == 0) begin
            report($sformatf("result with nothing pending: load %0d zero %0b",
                             data[6:0], user));
            return;
        end
        want = expected_loads.pop_front();
        if (data[6:0] !== want.load)
            report($sformatf("load_percent %0d, want %0d", data[6:0], want.load));
        if (user !== want.zero_flag)
            report($sformatf("zero_interval %0b, want %0b", user, want.zero_flag));
        if (data[7] !== 1'b0)
            report("tdata pad bit set");
    endtask

    task flush_leftovers();
        if (expected_loads.size() != 0)
            report($sformatf("%0d results never came", expected_loads.size()));
        expected_loads.delete();
    endtask
endclass

module tb_busy_counter_load_meter;

    localparam int HOLD_CYCLES   = 600;      // long receiver stall, fills the block
    localparam int SETTLE_CYCLES = 30;       // quiet time once no load is owed
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 360;      // five phases, about 1800 random requests

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // [31:0] counter_value, [32] powered, [96:33] timestamp_us, [103:97] zero
    logic [103:0] i_s_axis_tdata;
    // [0] opcode
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // [6:0] load_percent, [7] zero
    logic [7:0]   o_m_axis_tdata;
    // [0] zero_interval
    logic         o_m_axis_tuser;
    logic         i_cfg_we;
    logic         i_cfg_addr;
    logic [31:0]  i_cfg_wdata;

    busy_counter_load_meter dut (.*);

    load_checker loads;
    t_meter_req  stim_q[$];
    int          queued_count   = 0;
    int          accepted_count = 0;
    bit          hold_off_req   = 1'b0;

    // Generator view of the counter, so well-formed samples advance sensibly.
    logic [63:0] gen_stamp;
    logic [31:0] gen_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #8_000_000;
        $display("tb_busy_counter_load_meter: done, errors");
        $finish;
    end

    // Request monitor: decode the bus as the block sees it.
    always @(posedge i_clk) begin
        t_meter_req r;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            r.op      = i_s_axis_tuser;
            r.value   = i_s_axis_tdata[31:0];
            r.powered = i_s_axis_tdata[32];
            r.stamp   = i_s_axis_tdata[96:33];
            loads.note_request(r);
            accepted_count++;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            loads.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // Sender: bursts of random length, random gaps in between. Valid gets
    // at most one assignment per clock step.
    initial begin : sender
        t_meter_req r;
        int burst_left;
        int gap_left;
        burst_left = $urandom_range(1, 16);
        gap_left   = 0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= 1'b0;
        forever begin
            if (!i_rst_n || stim_q.size() == 0 || gap_left > 0) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                if (gap_left > 0) gap_left--;
            end else begin
                r = stim_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {7'd0, r.stamp, r.powered, r.value};
                i_s_axis_tuser  <= r.op;
                do @(posedge i_clk); while (!o_s_axis_tready);
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 9)) inside
                        [0:4]:   gap_left = 0;     // back to back
                        9:       gap_left = $urandom_range(20, 60);
                        default: gap_left = $urandom_range(1, 15);
                    endcase
                end
            end
        end
    end

    // Receiver: one of four stall patterns, picked anew at random after each stretch,
    // plus a long hold-off whenever the sequence asks for one.
    initial begin : receiver
        int mode;
        int stretch;
        int tick;
        tick = 0;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 300);
            repeat (stretch) begin
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    i_m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end else begin
                    tick++;
                    case (mode)
                        0:       i_m_axis_tready <= 1'b1;
                        1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       i_m_axis_tready <= (tick % 4 == 0);
                        default: i_m_axis_tready <= ($urandom_range(0, 9) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic void queue_item(logic op, logic [31:0] value, logic powered,
                                       logic [63:0] stamp);
        t_meter_req r;
        r.op      = op;
        r.value   = value;
        r.powered = powered;
        r.stamp   = stamp;
        stim_q.push_back(r);
        queued_count++;
    endfunction

    // Mostly well-formed traffic: a counter running at a random load, power
    // cycles with a saved count, some time slips and raw noise.
    function automatic void queue_random_traffic(int n);
        int          pushed;
        int          sel;
        int          k;
        logic [63:0] dt;
        logic [63:0] inc;
        logic [63:0] sum;
        logic [63:0] stamp;
        logic [31:0] saved;
        logic [31:0] reading;
        logic        pwr;
        pushed = 0;
        while (pushed < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                if ($urandom_range(0, 9) == 0) dt = 64'($urandom_range(1, 1 << 20));
                else dt = 64'($urandom_range(1, 3000));
                inc = dt * 64'(loads.ticks_per_us) * 64'($urandom_range(0, 130)) / 64'd100;
                sum = 64'(gen_count) + inc;
                // counter wraps at counter_max
                if (inc <= 64'(loads.counter_max) &&
                    (sum > 64'hFFFF_FFFF || $urandom_range(0, 7) == 0))
                    reading = 32'(sum - 64'(loads.counter_max));
                else
                    reading = sum[31:0];
                gen_stamp += dt;
                queue_item(bclm_pkg::OP_SAMPLE, reading, 1'b1, gen_stamp);
                gen_count = reading;
                pushed++;
            end else if (sel < 82) begin
                // power-off: count saved, maybe a few dark samples, power back on
                saved = ($urandom_range(0, 9) == 0) ? 32'd0 : gen_count;
                queue_item(bclm_pkg::OP_SAVE, saved, 1'($urandom_range(0, 1)),
                           {$urandom, $urandom});
                k = $urandom_range(0, 3);
                repeat (k) begin
                    gen_stamp += 64'($urandom_range(1, 5000));
                    queue_item(bclm_pkg::OP_SAMPLE, $urandom, 1'b0, gen_stamp);
                end
                case ($urandom_range(0, 2))
                    0:       reading = saved;
                    1:       reading = 32'($urandom_range(0, 5000));
                    default: reading = saved + 32'($urandom_range(0, 100000));
                endcase
                gen_stamp += 64'($urandom_range(1, 5000));
                queue_item(bclm_pkg::OP_SAMPLE, reading, 1'b1, gen_stamp);
                gen_count = reading;
                pushed += k + 2;
            end else if (sel < 90) begin
                // same timestamp again, or time running backwards
                if ($urandom_range(0, 1) == 0) stamp = gen_stamp;
                else stamp = gen_stamp - 64'($urandom_range(1, 1000));
                reading = gen_count + 32'($urandom_range(0, 50000));
                queue_item(bclm_pkg::OP_SAMPLE, reading, 1'($urandom_range(0, 1)), stamp);
                gen_stamp = stamp;
                gen_count = reading;
                pushed++;
            end else begin
                pwr     = 1'($urandom_range(0, 1));
                reading = $urandom;
                stamp   = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 0) begin
                    queue_item(bclm_pkg::OP_SAVE, reading, pwr, stamp);
                end else begin
                    queue_item(bclm_pkg::OP_SAMPLE, reading, pwr, stamp);
                    gen_stamp = stamp;
                    gen_count = pwr ? reading : 32'd0;
                end
                pushed++;
            end
        end
    endfunction

    task automatic set_register(logic idx, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        loads.write_reg(idx, value);
    endtask

    // Wait until every request is in and every load is out or the drain
    // limit runs out, then let the pipeline settle.
    task automatic drain_all();
        int waited;
        while (accepted_count != queued_count) @(posedge i_clk);
        waited = 0;
        while (loads.expected_loads.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        loads.flush_leftovers();
    endtask

    initial begin : sequence_main
        loads = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, register defaults: counter_max all ones, 26 ticks/us.
        queue_item(bclm_pkg::OP_SAMPLE, 32'd0,         1'b1, 64'd0);     // zero interval
        queue_item(bclm_pkg::OP_SAMPLE, 32'd26000,     1'b1, 64'd1000);  // full load
        queue_item(bclm_pkg::OP_SAMPLE, 32'd39000,     1'b1, 64'd2000);  // half load
        queue_item(bclm_pkg::OP_SAMPLE, 32'd39000,     1'b1, 64'd3000);  // idle
        queue_item(bclm_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, 64'd4000);  // unpowered, wraps
        queue_item(bclm_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 64'd4001);  // saturates
        queue_item(bclm_pkg::OP_SAMPLE, 32'h1234_5678, 1'b1,
                   64'd4001 + (64'd1 << 40));                              // dt at 2^40
        queue_item(bclm_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 1'b1,
                   64'd4001 + (64'd1 << 40) + (64'd1 << 40) - 64'd1);     // just under
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_1000, 1'b1, 64'd5);     // time backwards
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_1000, 1'b1, 64'd5);     // same stamp
        queue_item(bclm_pkg::OP_SAVE,   32'h0000_2000, 1'b1, 64'd0);     // saved above last
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_2000, 1'b1, 64'd105);   // reading equals saved
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_0010, 1'b1, 64'd205);   // differs, saved used
        queue_item(bclm_pkg::OP_SAVE,   32'h0000_0008, 1'b0, 64'd0);     // saved below last
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_0100, 1'b1, 64'd305);
        queue_item(bclm_pkg::OP_SAVE,   32'h0000_0500, 1'b1, 64'd77);
        queue_item(bclm_pkg::OP_SAVE,   32'd0,         1'b1, 64'd0);     // zero clears the save
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_0050, 1'b1, 64'd405);   // plain wrap
        queue_item(bclm_pkg::OP_SAVE,   32'hFFFF_FFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(bclm_pkg::OP_SAMPLE, 32'h0000_ABCD, 1'b0, 64'd505);   // dark, saved pending
        queue_item(bclm_pkg::OP_SAMPLE, 32'd0,         1'b1, 64'hFFFF_FFFF_FFFF_FFFF);

        // Random phases; registers change only with the block drained.
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                drain_all();
                case (ph)
                    1: begin
                        set_register(bclm_pkg::REG_COUNTER_MAX, 32'd1);
                        set_register(bclm_pkg::REG_TICKS_PER_US, 32'd1);
                    end
                    2: begin
                        set_register(bclm_pkg::REG_TICKS_PER_US, 32'd1023);
                        set_register(bclm_pkg::REG_COUNTER_MAX, 32'hFFFF_FFFF);
                    end
                    3: begin
                        set_register(bclm_pkg::REG_COUNTER_MAX,
                                     32'($urandom_range(1, 32'hFFFF_FFFE)));
                        set_register(bclm_pkg::REG_TICKS_PER_US,
                                     32'($urandom_range(1, 1023)));
                    end
                    default: begin
                        set_register(bclm_pkg::REG_COUNTER_MAX, 32'hFFFF_FFFF);
                        set_register(bclm_pkg::REG_TICKS_PER_US, 32'd26);
                    end
                endcase
            end
            gen_stamp = {$urandom, $urandom} >> $urandom_range(0, 63);
            gen_count = loads.last_count;
            queue_random_traffic(PHASE_ITEMS);
            // stall the result side while the sender keeps offering
            if (ph == 0 || ph == 3) hold_off_req = 1'b1;
        end

        drain_all();
        if (loads.error_count == 0) begin
            $display("tb_busy_counter_load_meter: done, clean");
        end else begin
            $display("tb_busy_counter_load_meter: done, errors");
        end
        $finish;
    end

endmodule
